### rtl/core/event_rate_moving_average_top_macros.svh
// Assertion macros for the RTL of the event rate meter.
`ifndef EVENT_RATE_MOVING_AVERAGE_TOP_MACROS_SVH
`define EVENT_RATE_MOVING_AVERAGE_TOP_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define ERMA_ASSERT_IMP(lbl, clk, rst_n, a, b) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed: same-cycle implication");
// Next-cycle implication, disabled during reset.
`define ERMA_ASSERT_NXT(lbl, clk, rst_n, a, b) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ERMA_ASSERT_IMP(lbl, clk, rst_n, a, b)
`define ERMA_ASSERT_NXT(lbl, clk, rst_n, a, b)
`endif
`endif

### rtl/core/erma_pkg.sv
package erma_pkg;

    // Default window depth.
    localparam int SAMPLE_DEPTH_DEF = 1024;

    // Field and register widths.
    localparam int SAMPLE_W  = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int SMAX_W    = 11;
    localparam int FRAC_W    = 16;
    localparam int MUL_W     = 32;
    localparam int DIV_DW    = 2 * MUL_W + FRAC_W;
    localparam int DIV_VW    = 32;

    localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

    // Register reset values.
    localparam logic [31:0]       RATE_PERIOD_RST = 32'd1000000;
    localparam logic [SMAX_W-1:0] SAMPLE_MAX_RST  = 11'd64;
    localparam logic [31:0]       MIN_GAP_RST     = 32'd1000000;

    // Register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATE_PERIOD        = 3'd0,
        CFG_SAMPLE_MAX         = 3'd1,
        CFG_AUTO_MAX_PERIOD    = 3'd2,
        CFG_RATE_UPDATE_PERIOD = 3'd3,
        CFG_MIN_GAP_TIME       = 3'd4
    } cfg_idx_t;

    // Item opcodes.
    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    typedef struct packed {
        logic        op;
        logic [15:0] tick_amount;
        logic [23:0] time_delta;
    } in_item_t;

    typedef struct packed {
        logic [31:0] rate_value;
        logic        sample_pushed;
    } out_item_t;

    typedef struct packed {
        logic             start;
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } mul_cmd_t;

    typedef struct packed {
        logic              start;
        logic [DIV_DW-1:0] dividend;
        logic [DIV_VW-1:0] divisor;
    } div_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TICK,
        ST_UPD,
        ST_TRIM_RD,
        ST_TRIM_SUB,
        ST_DECIDE,
        ST_MUL,
        ST_DIV,
        ST_DROP_RD,
        ST_DROP_SUB,
        ST_STORE,
        ST_RECOMP,
        ST_AVG,
        ST_TIMER,
        ST_FIN
    } state_t;

    // Saturating 32-bit add.
    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? MAX32 : s[31:0];
    endfunction

endpackage

### rtl/core/event_rate_moving_average_top.sv
// Event rate meter with a moving-average window. Tick requests add a count, update
// requests advance time and may push a 16.16 rate sample into a ring window whose
// average is reported with every result. An update that pushes a measured sample
// runs a bit-serial 32x32 multiplier and an 80-bit restoring divider, and a
// recomputation of the average runs the same divider again; a zero sample skips the
// multiply and the first division, and an update whose rate timer expires with a
// dirty average adds the same recomputation. Each sample dropped from the window is
// read through the ring memory read port and then subtracted from the sum, also when
// writing sample_max or auto resizing shrinks the window. A stalled result holds the
// block until it is taken. The ring needs no clearing pass after reset.
`include "event_rate_moving_average_top_macros.svh"

module event_rate_moving_average_top #(
    parameter int SAMPLE_DEPTH = erma_pkg::SAMPLE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  erma_pkg::in_item_t             in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output erma_pkg::out_item_t            out_data,
    input  logic                           cfg_we,
    input  logic [erma_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [erma_pkg::CFG_W-1:0]     cfg_data
);

    localparam int AW = $clog2(SAMPLE_DEPTH);
    localparam int CW = $clog2(SAMPLE_DEPTH + 1);
    localparam int SW = 32 + $clog2(SAMPLE_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(SAMPLE_DEPTH);
    localparam logic [CW-1:0] LIMIT_RST =
        (int'(erma_pkg::SAMPLE_MAX_RST) < SAMPLE_DEPTH) ?
        CW'(erma_pkg::SAMPLE_MAX_RST) : CW'(SAMPLE_DEPTH);

    // Limit a count to the window depth.
    function automatic logic [CW-1:0] clamp_depth(input logic [15:0] v);
        return (v > 16'(SAMPLE_DEPTH)) ? DEPTH_C : CW'(v);
    endfunction

    // Configuration registers.
    logic [31:0]                 rate_period_reg;
    logic [erma_pkg::SMAX_W-1:0] sample_max_reg;
    logic [31:0]                 auto_max_period_reg;
    logic [31:0]                 rate_update_period_reg;
    logic [31:0]                 min_gap_time_reg;

    // Meter state.
    erma_pkg::state_t state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] limit_reg, limit_next;
    logic [SW-1:0] sum_reg, sum_next;
    logic [31:0]   tick_reg, tick_next;
    logic [31:0]   elapsed_reg, elapsed_next;
    logic [31:0]   idle_reg, idle_next;
    logic [31:0]   last_reg, last_next;
    logic [31:0]   rtimer_reg, rtimer_next;
    logic [CW-1:0] ssr_reg, ssr_next;
    logic [31:0]   ctimer_reg, ctimer_next;
    logic          dirty_reg, dirty_next;
    logic [31:0]   rate_reg, rate_next;
    logic          active_reg, active_next;
    logic          pushed_reg, pushed_next;
    logic          from_tick_reg, from_tick_next;
    logic          avg_ret_fin_reg, avg_ret_fin_next;
    logic [31:0]   sample_reg, sample_next;
    erma_pkg::in_item_t item_reg;
    logic                out_valid_reg, out_valid_next;
    erma_pkg::out_item_t out_data_reg, out_data_next;

    // Memory and arithmetic unit links.
    logic                          mem_we;
    logic [AW-1:0]                 mem_waddr;
    logic                          mem_re;
    logic [erma_pkg::SAMPLE_W-1:0] mem_rdata;
    erma_pkg::mul_cmd_t            mul_cmd;
    logic                          mul_busy;
    logic                          mul_done;
    logic [2*erma_pkg::MUL_W-1:0]  mul_prod;
    erma_pkg::div_cmd_t            div_cmd;
    logic                          div_busy;
    logic                          div_done;
    logic [erma_pkg::DIV_DW-1:0]   div_q;

    // Shared combinational terms.
    logic [31:0]   delta32;
    logic [31:0]   rtimer_sum;
    logic [31:0]   ctimer_sum;
    logic [32:0]   twice_last;
    logic [32:0]   gap;
    logic          over_gap;
    logic [CW:0]   waddr_sum;
    logic [AW-1:0] head_inc;
    logic          out_free;
    logic          accept;
    logic [31:0]   div_sample;
    logic [15:0]   nl_raw;

    always_comb
    begin
        delta32    = 32'(item_reg.time_delta);
        rtimer_sum = erma_pkg::sat_add32(rtimer_reg, delta32);
        ctimer_sum = erma_pkg::sat_add32(ctimer_reg, delta32);
        twice_last = {last_reg, 1'b0};
        gap        = ({1'b0, min_gap_time_reg} < twice_last) ?
                     {1'b0, min_gap_time_reg} : twice_last;
        over_gap   = {1'b0, idle_reg} > gap;
        waddr_sum  = (CW+1)'(head_reg) + (CW+1)'(count_reg);
        if (waddr_sum >= (CW+1)'(SAMPLE_DEPTH))
        begin
            waddr_sum = waddr_sum - (CW+1)'(SAMPLE_DEPTH);
        end
        mem_waddr  = waddr_sum[AW-1:0];
        head_inc   = (head_reg == AW'(SAMPLE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
        out_free   = !out_valid_reg || !out_stall;
        div_sample = (div_q[erma_pkg::DIV_DW-1:32] != '0) ? erma_pkg::MAX32 : div_q[31:0];
        nl_raw     = (16'(ssr_reg) > 16'(sample_max_reg)) ?
                     16'(ssr_reg) : 16'(sample_max_reg);
    end

    assign in_stall = !((state_reg == erma_pkg::ST_IDLE) && (count_reg <= limit_reg));
    assign accept   = in_valid && !in_stall;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            erma_pkg::ST_IDLE:
            begin
                if (count_reg > limit_reg)
                begin
                    state_next = erma_pkg::ST_TRIM_RD;
                end
                else if (accept)
                begin
                    state_next = (in_data.op == erma_pkg::OP_TICK) ?
                                 erma_pkg::ST_TICK : erma_pkg::ST_UPD;
                end
            end
            erma_pkg::ST_TICK:     state_next = erma_pkg::ST_FIN;
            erma_pkg::ST_UPD:      state_next = erma_pkg::ST_TRIM_RD;
            erma_pkg::ST_TRIM_RD:
            begin
                if (count_reg > limit_reg)
                begin
                    state_next = erma_pkg::ST_TRIM_SUB;
                end
                else
                begin
                    state_next = active_reg ? erma_pkg::ST_DECIDE : erma_pkg::ST_IDLE;
                end
            end
            erma_pkg::ST_TRIM_SUB: state_next = erma_pkg::ST_TRIM_RD;
            erma_pkg::ST_DECIDE:
            begin
                if (tick_reg != '0)
                begin
                    state_next = (elapsed_reg == '0) ? erma_pkg::ST_DROP_RD : erma_pkg::ST_MUL;
                end
                else if (over_gap)
                begin
                    state_next = erma_pkg::ST_DROP_RD;
                end
                else
                begin
                    state_next = erma_pkg::ST_TIMER;
                end
            end
            erma_pkg::ST_MUL:
            begin
                if (mul_done)
                begin
                    state_next = erma_pkg::ST_DIV;
                end
            end
            erma_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = erma_pkg::ST_DROP_RD;
                end
            end
            erma_pkg::ST_DROP_RD:
            begin
                state_next = ((count_reg >= limit_reg) && (count_reg != '0)) ?
                             erma_pkg::ST_DROP_SUB : erma_pkg::ST_STORE;
            end
            erma_pkg::ST_DROP_SUB: state_next = erma_pkg::ST_STORE;
            erma_pkg::ST_STORE:
            begin
                state_next = (rate_update_period_reg != '0) ?
                             erma_pkg::ST_TIMER : erma_pkg::ST_RECOMP;
            end
            erma_pkg::ST_RECOMP:
            begin
                if ((sum_reg == '0) || (count_reg == '0))
                begin
                    state_next = avg_ret_fin_reg ? erma_pkg::ST_FIN : erma_pkg::ST_TIMER;
                end
                else
                begin
                    state_next = erma_pkg::ST_AVG;
                end
            end
            erma_pkg::ST_AVG:
            begin
                if (div_done)
                begin
                    state_next = avg_ret_fin_reg ? erma_pkg::ST_FIN : erma_pkg::ST_TIMER;
                end
            end
            erma_pkg::ST_TIMER:
            begin
                if ((rate_update_period_reg != '0) && (ctimer_sum >= rate_update_period_reg)
                    && dirty_reg)
                begin
                    state_next = erma_pkg::ST_RECOMP;
                end
                else
                begin
                    state_next = erma_pkg::ST_FIN;
                end
            end
            erma_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = erma_pkg::ST_IDLE;
                end
            end
            default:               state_next = erma_pkg::ST_IDLE;
        endcase
    end

    // Datapath and unit controls for each state.
    always_comb
    begin
        head_next        = head_reg;
        count_next       = count_reg;
        limit_next       = limit_reg;
        sum_next         = sum_reg;
        tick_next        = tick_reg;
        elapsed_next     = elapsed_reg;
        idle_next        = idle_reg;
        last_next        = last_reg;
        rtimer_next      = rtimer_reg;
        ssr_next         = ssr_reg;
        ctimer_next      = ctimer_reg;
        dirty_next       = dirty_reg;
        rate_next        = rate_reg;
        active_next      = active_reg;
        pushed_next      = pushed_reg;
        from_tick_next   = from_tick_reg;
        avg_ret_fin_next = avg_ret_fin_reg;
        sample_next      = sample_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_data_next    = out_data_reg;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        mul_cmd          = '{start: 1'b0, a: tick_reg, b: rate_period_reg};
        div_cmd          = '{start: 1'b0, dividend: {mul_prod, {erma_pkg::FRAC_W{1'b0}}},
                             divisor: elapsed_reg};

        case (state_reg)
            erma_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    active_next = 1'b1;
                    pushed_next = 1'b0;
                end
            end
            erma_pkg::ST_TICK:
            begin
                tick_next = erma_pkg::sat_add32(tick_reg, 32'(item_reg.tick_amount));
            end
            erma_pkg::ST_UPD:
            begin
                elapsed_next = erma_pkg::sat_add32(elapsed_reg, delta32);
                idle_next    = erma_pkg::sat_add32(idle_reg, delta32);
                if (auto_max_period_reg != '0)
                begin
                    rtimer_next = rtimer_sum;
                    if (rtimer_sum >= auto_max_period_reg)
                    begin
                        limit_next  = clamp_depth(nl_raw);
                        ssr_next    = '0;
                        rtimer_next = '0;
                    end
                end
            end
            erma_pkg::ST_TRIM_RD:
            begin
                mem_re = count_reg > limit_reg;
            end
            erma_pkg::ST_TRIM_SUB, erma_pkg::ST_DROP_SUB:
            begin
                sum_next   = sum_reg - SW'(mem_rdata);
                head_next  = head_inc;
                count_next = count_reg - 1'b1;
            end
            erma_pkg::ST_DECIDE:
            begin
                from_tick_next = tick_reg != '0;
                sample_next    = (tick_reg != '0) ? erma_pkg::MAX32 : '0;
                mul_cmd.start  = (tick_reg != '0) && (elapsed_reg != '0);
            end
            erma_pkg::ST_MUL:
            begin
                div_cmd.start = mul_done;
            end
            erma_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    sample_next = div_sample;
                end
            end
            erma_pkg::ST_DROP_RD:
            begin
                mem_re = (count_reg >= limit_reg) && (count_reg != '0);
            end
            erma_pkg::ST_STORE:
            begin
                // Store the sample if the window has room, then retire the pending interval.
                if (count_reg < limit_reg)
                begin
                    mem_we     = 1'b1;
                    sum_next   = sum_reg + SW'(sample_reg);
                    count_next = count_reg + 1'b1;
                end
                if (ssr_reg < DEPTH_C)
                begin
                    ssr_next = ssr_reg + 1'b1;
                end
                if (rate_update_period_reg != '0)
                begin
                    dirty_next = 1'b1;
                end
                avg_ret_fin_next = 1'b0;
                pushed_next      = 1'b1;
                idle_next        = '0;
                if (from_tick_reg)
                begin
                    tick_next    = '0;
                    last_next    = elapsed_reg;
                    elapsed_next = '0;
                end
            end
            erma_pkg::ST_RECOMP:
            begin
                div_cmd.dividend = erma_pkg::DIV_DW'(sum_reg);
                div_cmd.divisor  = erma_pkg::DIV_VW'(count_reg);
                if ((sum_reg == '0) || (count_reg == '0))
                begin
                    rate_next  = '0;
                    dirty_next = 1'b0;
                end
                else
                begin
                    div_cmd.start = 1'b1;
                end
            end
            erma_pkg::ST_AVG:
            begin
                if (div_done)
                begin
                    rate_next  = div_q[31:0];
                    dirty_next = 1'b0;
                end
            end
            erma_pkg::ST_TIMER:
            begin
                if (rate_update_period_reg != '0)
                begin
                    ctimer_next = ctimer_sum;
                    if (ctimer_sum >= rate_update_period_reg)
                    begin
                        ctimer_next      = '0;
                        avg_ret_fin_next = 1'b1;
                    end
                end
            end
            erma_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{rate_value: rate_reg, sample_pushed: pushed_reg};
                    active_next    = 1'b0;
                end
            end
            default:
            begin
                active_next = 1'b0;
            end
        endcase

        // A sample_max write reloads the window limit; the idle trim drops the excess.
        if (cfg_we && (cfg_index == erma_pkg::CFG_SAMPLE_MAX))
        begin
            limit_next = clamp_depth(16'(cfg_data[10:0]));
        end
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_period_reg        <= erma_pkg::RATE_PERIOD_RST;
            sample_max_reg         <= erma_pkg::SAMPLE_MAX_RST;
            auto_max_period_reg    <= '0;
            rate_update_period_reg <= '0;
            min_gap_time_reg       <= erma_pkg::MIN_GAP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                erma_pkg::CFG_RATE_PERIOD:        rate_period_reg <= cfg_data;
                erma_pkg::CFG_SAMPLE_MAX:         sample_max_reg <= cfg_data[10:0];
                erma_pkg::CFG_AUTO_MAX_PERIOD:    auto_max_period_reg <= cfg_data;
                erma_pkg::CFG_RATE_UPDATE_PERIOD: rate_update_period_reg <= cfg_data;
                erma_pkg::CFG_MIN_GAP_TIME:       min_gap_time_reg <= cfg_data;
                default:                          rate_period_reg <= rate_period_reg;
            endcase
        end
    end

    // Control and meter state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= erma_pkg::ST_IDLE;
            head_reg        <= '0;
            count_reg       <= '0;
            limit_reg       <= LIMIT_RST;
            sum_reg         <= '0;
            tick_reg        <= '0;
            elapsed_reg     <= '0;
            idle_reg        <= '0;
            last_reg        <= erma_pkg::MAX32;
            rtimer_reg      <= '0;
            ssr_reg         <= '0;
            ctimer_reg      <= '0;
            dirty_reg       <= 1'b0;
            rate_reg        <= '0;
            active_reg      <= 1'b0;
            pushed_reg      <= 1'b0;
            from_tick_reg   <= 1'b0;
            avg_ret_fin_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            head_reg        <= head_next;
            count_reg       <= count_next;
            limit_reg       <= limit_next;
            sum_reg         <= sum_next;
            tick_reg        <= tick_next;
            elapsed_reg     <= elapsed_next;
            idle_reg        <= idle_next;
            last_reg        <= last_next;
            rtimer_reg      <= rtimer_next;
            ssr_reg         <= ssr_next;
            ctimer_reg      <= ctimer_next;
            dirty_reg       <= dirty_next;
            rate_reg        <= rate_next;
            active_reg      <= active_next;
            pushed_reg      <= pushed_next;
            from_tick_reg   <= from_tick_next;
            avg_ret_fin_reg <= avg_ret_fin_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        out_data_reg <= out_data_next;
        if (accept)
        begin
            item_reg <= in_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    erma_ring_mem #(
        .DEPTH (SAMPLE_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (sample_reg),
        .rd_en   (mem_re),
        .rd_addr (head_reg),
        .rd_data (mem_rdata)
    );

    erma_serial_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (mul_cmd),
        .busy    (mul_busy),
        .done    (mul_done),
        .product (mul_prod)
    );

    erma_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (div_cmd),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    // The window is trimmed before a sample decision is made.
    `ERMA_ASSERT_IMP(a_trimmed, clk, rst_n, state_reg == erma_pkg::ST_DECIDE,
        count_reg <= limit_reg)
    // The multiplier only runs while the sample product is awaited.
    `ERMA_ASSERT_IMP(a_mul_owned, clk, rst_n, mul_busy, state_reg == erma_pkg::ST_MUL)
    // The divider only runs for a sample or an average.
    `ERMA_ASSERT_IMP(a_div_owned, clk, rst_n, div_busy,
        (state_reg == erma_pkg::ST_DIV) || (state_reg == erma_pkg::ST_AVG))
    // A stored push leaves the window non-empty unless its limit is zero.
    `ERMA_ASSERT_NXT(a_push_fills, clk, rst_n, state_reg == erma_pkg::ST_STORE,
        (count_reg != '0) || (limit_reg == '0))

endmodule

### rtl/core/erma_ring_mem.sv
module erma_ring_mem #(
    parameter int DEPTH = erma_pkg::SAMPLE_DEPTH_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [AW-1:0]                 wr_addr,
    input  logic [erma_pkg::SAMPLE_W-1:0] wr_data,
    input  logic                          rd_en,
    input  logic [AW-1:0]                 rd_addr,
    output logic [erma_pkg::SAMPLE_W-1:0] rd_data
);

    logic [erma_pkg::SAMPLE_W-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/core/erma_serial_mul.sv
module erma_serial_mul (
    input  logic                         clk,
    input  logic                         rst_n,
    input  erma_pkg::mul_cmd_t           cmd,
    output logic                         busy,
    output logic                         done,
    output logic [2*erma_pkg::MUL_W-1:0] product
);

    localparam int W  = erma_pkg::MUL_W;
    localparam int CN = $clog2(W);

    logic          busy_reg;
    logic          done_reg;
    logic [CN-1:0] cnt_reg;
    logic [W-1:0]  a_reg;
    logic [W-1:0]  hi_reg;
    logic [W-1:0]  lo_reg;
    logic [W-1:0]  addend;
    logic [W:0]    sum;

    // One multiplier bit per cycle: add the multiplicand and shift right.
    always_comb
    begin
        addend = lo_reg[0] ? a_reg : '0;
        sum    = {1'b0, hi_reg} + {1'b0, addend};
    end

    // Control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (cmd.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CN'(W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Partial product shift register.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            a_reg  <= cmd.a;
            lo_reg <= cmd.b;
            hi_reg <= '0;
        end
        else if (busy_reg)
        begin
            hi_reg <= sum[W:1];
            lo_reg <= {sum[0], lo_reg[W-1:1]};
        end
    end

    assign busy    = busy_reg;
    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

endmodule

### rtl/core/erma_serial_div.sv
module erma_serial_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  erma_pkg::div_cmd_t        cmd,
    output logic                      busy,
    output logic                      done,
    output logic [erma_pkg::DIV_DW-1:0] quotient
);

    localparam int DW = erma_pkg::DIV_DW;
    localparam int VW = erma_pkg::DIV_VW;
    localparam int CN = $clog2(DW);

    logic          busy_reg;
    logic          done_reg;
    logic [CN-1:0] cnt_reg;
    logic [DW-1:0] q_reg;
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] div_reg;
    logic [VW:0]   shifted;
    logic          ge;
    logic [VW:0]   diff;

    // Restoring division, one quotient bit per cycle.
    always_comb
    begin
        shifted = {rem_reg, q_reg[DW-1]};
        ge      = shifted >= {1'b0, div_reg};
        diff    = shifted - {1'b0, div_reg};
    end

    // Control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (cmd.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CN'(DW - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Dividend and quotient share one shift register.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            q_reg   <= cmd.dividend;
            div_reg <= cmd.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[DW-2:0], ge};
            rem_reg <= ge ? diff[VW-1:0] : shifted[VW-1:0];
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = q_reg;

endmodule
